FILE: rtl/core/uart_rx_tx_buffer_engine_macros.svh
// Assertion macros used by the checker file of the serial buffer engine.
`ifndef UART_RX_TX_BUFFER_ENGINE_MACROS_SVH
`define UART_RX_TX_BUFFER_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UBUF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubuf check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UBUF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubuf check failed: next-cycle rule");

`endif

FILE: rtl/core/ubuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubuf_pkg
// Event codes, status codes and the per-side result type of the serial
// buffer engine.
// ----------------------------------------------------------------------------
package ubuf_pkg;

    // Event codes on the func field.
    localparam logic [2:0] FUNC_RX_BYTE  = 3'd0;
    localparam logic [2:0] FUNC_RX_READ  = 3'd1;
    localparam logic [2:0] FUNC_TX_LOAD  = 3'd2;
    localparam logic [2:0] FUNC_TX_SLOT  = 3'd3;
    localparam logic [2:0] FUNC_TX_CLEAR = 3'd4;

    // Status codes reported with each result.
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_RX_EMPTY  = 3'd1;
    localparam logic [2:0] STAT_RX_DROP   = 3'd2;
    localparam logic [2:0] STAT_TX_BUSY   = 3'd3;
    localparam logic [2:0] STAT_RX_OVWR   = 3'd4;

    // Outcome of one event on one side; the byte itself follows from the
    // memory in the next cycle.
    typedef struct packed {
        logic [2:0] status;
        logic       rd_byte;
        logic       tx_busy;
        logic       tx_done;
    } t_side_res;

endpackage

FILE: rtl/core/uart_rx_tx_buffer_engine.sv
`timescale 1ns / 1ps
// The engine takes one event per transfer and returns one result for it. An
// event is handled as follows: in the accept cycle the pointers update and
// the ring or message RAM is addressed, in the next cycle the registered RAM
// word lands in the output register. A new event is accepted in the same cycle
// in which the waiting result transfers out, and not while that result stays
// stalled; no new event is accepted before the RAM word of the last one has
// landed. Neither RAM needs a clearing pass after reset; the block is ready to
// accept an event as soon as reset is released.
// ----------------------------------------------------------------------------
// uart_rx_tx_buffer_engine
// Receive ring and transmit message buffer with a valid/ready event port and
// a valid/ready result port.
// ----------------------------------------------------------------------------
module uart_rx_tx_buffer_engine
    import ubuf_pkg::*;
#(
    parameter int RX_DEPTH = 8192,
    parameter int TX_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_rx_error,
    input  logic       i_tx_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic [2:0] o_status,
    output logic       o_tx_busy,
    output logic       o_tx_done
);

    t_side_res  rx_res, tx_res, acc_res;
    logic [7:0] rx_rdata, tx_rdata;
    logic       go;

    logic       r_pend;
    t_side_res  r_res;
    logic       r_from_rx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_bvalid;
    logic [2:0] r_status;
    logic       r_busy;
    logic       r_done;

    // One event in flight; the output slot must be free or draining.
    assign o_ready = !r_pend && (!r_ov || i_ready);
    assign go      = i_valid && o_ready;

    ubuf_rx #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_rx_error  (i_rx_error),
        .o_res       (rx_res),
        .o_rdata     (rx_rdata)
    );

    ubuf_tx #(
        .TX_DEPTH (TX_DEPTH)
    ) u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_tx_last   (i_tx_last),
        .o_res       (tx_res),
        .o_rdata     (tx_rdata)
    );

    // Merge the two sides; busy always reflects the transmit side.
    always_comb begin
        acc_res         = tx_res;
        acc_res.status  = rx_res.status | tx_res.status;
        acc_res.rd_byte = rx_res.rd_byte | tx_res.rd_byte;
    end

    // Control: pending flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_pend <= go;
            if (r_pend) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload: hold the decoded result, then fold in the RAM word.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_res     <= acc_res;
            r_from_rx <= rx_res.rd_byte;
        end
        if (r_pend) begin
            r_bvalid <= r_res.rd_byte;
            r_status <= r_res.status;
            r_busy   <= r_res.tx_busy;
            r_done   <= r_res.tx_done;
            if (!r_res.rd_byte) begin
                r_byte <= 8'd0;
            end else if (r_from_rx) begin
                r_byte <= rx_rdata;
            end else begin
                r_byte <= tx_rdata;
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_byte;
    assign o_out_valid = r_bvalid;
    assign o_status    = r_status;
    assign o_tx_busy   = r_busy;
    assign o_tx_done   = r_done;

endmodule

FILE: rtl/core/ubuf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubuf_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ubuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled; the read returns the old contents of the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ubuf_rx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubuf_rx
// Receive ring: in and out pointers around one RAM, with error drop,
// empty detection and overwrite report.
// ----------------------------------------------------------------------------
module ubuf_rx
    import ubuf_pkg::*;
#(
    parameter int RX_DEPTH = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [2:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_rx_error,
    output t_side_res  o_res,
    output logic [7:0] o_rdata
);

    localparam int AW = $clog2(RX_DEPTH);

    logic [AW-1:0] r_in_ptr, n_in_ptr;
    logic [AW-1:0] r_out_ptr, n_out_ptr;
    logic [AW-1:0] in_inc;
    logic          we;
    logic [AW-1:0] addr;

    assign in_inc = r_in_ptr + AW'(1);

    // Decode the event; pointers wrap at the power-of-two depth.
    always_comb begin
        n_in_ptr  = r_in_ptr;
        n_out_ptr = r_out_ptr;
        we        = 1'b0;
        addr      = r_out_ptr;
        o_res     = '{status: STAT_OK, rd_byte: 1'b0, tx_busy: 1'b0, tx_done: 1'b0};
        case (i_func)
            FUNC_RX_BYTE: begin
                if (i_rx_error) begin
                    o_res.status = STAT_RX_DROP;
                end else begin
                    we       = i_go;
                    addr     = r_in_ptr;
                    n_in_ptr = in_inc;
                    if (in_inc == r_out_ptr) begin
                        o_res.status = STAT_RX_OVWR;
                    end
                end
            end
            FUNC_RX_READ: begin
                if (r_out_ptr == r_in_ptr) begin
                    o_res.status = STAT_RX_EMPTY;
                end else begin
                    o_res.rd_byte = 1'b1;
                    n_out_ptr     = r_out_ptr + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Pointers move only on an accepted event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ptr  <= '0;
            r_out_ptr <= '0;
        end else if (i_go) begin
            r_in_ptr  <= n_in_ptr;
            r_out_ptr <= n_out_ptr;
        end
    end

    ubuf_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (i_data_byte),
        .o_rdata (o_rdata)
    );

endmodule

FILE: rtl/core/ubuf_tx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubuf_tx
// Transmit message buffer: loads bytes until the last flag, then hands out
// one byte per slot event from its RAM.
// ----------------------------------------------------------------------------
module ubuf_tx
    import ubuf_pkg::*;
#(
    parameter int TX_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [2:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_tx_last,
    output t_side_res  o_res,
    output logic [7:0] o_rdata
);

    localparam int AW = $clog2(TX_DEPTH);
    localparam int FW = AW + 1;

    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_send, n_send;
    logic          r_active, n_active;
    logic [FW-1:0] send_inc;
    logic          we;
    logic [AW-1:0] addr;

    assign send_inc = r_send + FW'(1);

    // Decode the event and work out the next counters.
    always_comb begin
        n_fill   = r_fill;
        n_send   = r_send;
        n_active = r_active;
        we       = 1'b0;
        addr     = r_send[AW-1:0];
        o_res    = '{status: STAT_OK, rd_byte: 1'b0, tx_busy: 1'b0, tx_done: 1'b0};
        case (i_func)
            FUNC_TX_LOAD: begin
                if (r_active) begin
                    o_res.status = STAT_TX_BUSY;
                end else begin
                    if (r_fill < FW'(TX_DEPTH)) begin
                        we     = i_go;
                        addr   = r_fill[AW-1:0];
                        n_fill = r_fill + FW'(1);
                    end
                    if (i_tx_last) begin
                        n_active = 1'b1;
                        n_send   = '0;
                    end
                end
            end
            FUNC_TX_SLOT: begin
                if (r_active && (r_send < r_fill)) begin
                    o_res.rd_byte = 1'b1;
                    n_send        = send_inc;
                    if (send_inc >= r_fill) begin
                        n_active      = 1'b0;
                        n_fill        = '0;
                        n_send        = '0;
                        o_res.tx_done = 1'b1;
                    end
                end else if (r_active) begin
                    n_active = 1'b0;
                    n_fill   = '0;
                    n_send   = '0;
                end
            end
            FUNC_TX_CLEAR: begin
                n_active = 1'b0;
                n_fill   = '0;
                n_send   = '0;
            end
            default: begin
            end
        endcase
        o_res.tx_busy = n_active;
    end

    // Counters move only on an accepted event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_send   <= '0;
            r_active <= 1'b0;
        end else if (i_go) begin
            r_fill   <= n_fill;
            r_send   <= n_send;
            r_active <= n_active;
        end
    end

    ubuf_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (i_data_byte),
        .o_rdata (o_rdata)
    );

endmodule

FILE: rtl/core/ubuf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubuf_chk
// Port-level checks of the serial buffer engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_rx_tx_buffer_engine_macros.svh"

module ubuf_chk
    import ubuf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid,
    input logic [2:0] o_status,
    input logic       o_tx_busy,
    input logic       o_tx_done
);

    // A result without a byte shows a zero byte.
    `UBUF_ASSERT_IMP(a_zero_byte, i_clk, i_rst_n, o_valid && !o_out_valid, o_out_byte == 8'd0)

    // Finishing a message sends a byte and leaves the transmitter idle.
    `UBUF_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_valid && o_tx_done, o_out_valid && !o_tx_busy && (o_status == STAT_OK))

    // An empty, drop or busy report never carries a byte.
    `UBUF_ASSERT_IMP(a_err_nobyte, i_clk, i_rst_n, o_valid && ((o_status == STAT_RX_EMPTY) || (o_status == STAT_RX_DROP) || (o_status == STAT_TX_BUSY)), !o_out_valid)

    // Only one event is in flight: after a transfer in, the port closes.
    `UBUF_ASSERT_NXT(a_one_inflight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // A stalled result holds its payload.
    `UBUF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_byte) && $stable(o_status))

endmodule

bind uart_rx_tx_buffer_engine ubuf_chk u_ubuf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_byte  (o_out_byte),
    .o_out_valid (o_out_valid),
    .o_status    (o_status),
    .o_tx_busy   (o_tx_busy),
    .o_tx_done   (o_tx_done)
);
